// ===== rtl/klx_pkg.sv =====
`default_nettype none

package klx_pkg;

  // Defaults for the top-level parameters
  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int KEYWORD_MAX_DEF = 9;

  localparam int LEN_BITS   = 16;
  localparam int KIND_BITS  = 6;
  localparam int KW_COUNT   = 12;
  localparam int KW_LEN_MAX = 9;   // longest keyword
  localparam int OUT_DEPTH  = 4;   // result queue, power of two

  typedef logic [LEN_BITS-1:0]  len_t;
  typedef logic [KIND_BITS-1:0] kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_GT,
    MODE_LT,
    MODE_EQ,
    MODE_BANG,
    MODE_ERROR
  } lex_mode_t;

  localparam kind_t K_IDENT    = 6'd0;
  localparam kind_t K_INT      = 6'd1;
  localparam kind_t K_BIND     = 6'd2;
  localparam kind_t K_IS       = 6'd3;
  localparam kind_t K_EMIT     = 6'd4;
  localparam kind_t K_CHECK    = 6'd5;
  localparam kind_t K_OTHERW   = 6'd6;
  localparam kind_t K_CYCLE    = 6'd7;
  localparam kind_t K_FORGE    = 6'd8;
  localparam kind_t K_YIELD    = 6'd9;
  localparam kind_t K_BOOL     = 6'd10;
  localparam kind_t K_INT_TY   = 6'd11;
  localparam kind_t K_BOOL_TY  = 6'd12;
  localparam kind_t K_PLUS     = 6'd13;
  localparam kind_t K_MINUS    = 6'd14;
  localparam kind_t K_STAR     = 6'd15;
  localparam kind_t K_SLASH    = 6'd16;
  localparam kind_t K_GT       = 6'd17;
  localparam kind_t K_GE       = 6'd18;
  localparam kind_t K_LT       = 6'd19;
  localparam kind_t K_LE       = 6'd20;
  localparam kind_t K_EQEQ     = 6'd21;
  localparam kind_t K_NE       = 6'd22;
  localparam kind_t K_COLON    = 6'd23;
  localparam kind_t K_SEMI     = 6'd24;
  localparam kind_t K_COMMA    = 6'd25;
  localparam kind_t K_LPAREN   = 6'd26;
  localparam kind_t K_RPAREN   = 6'd27;
  localparam kind_t K_LBRACE   = 6'd28;
  localparam kind_t K_RBRACE   = 6'd29;
  localparam kind_t K_EOF      = 6'd30;
  localparam kind_t K_BADOP    = 6'd31;
  localparam kind_t K_BADSYM   = 6'd32;
  localparam kind_t K_BADCHAR  = 6'd33;

  typedef logic [8*KW_LEN_MAX-1:0] kw_str_t;

  // Keyword text is right-justified: last character in the low byte
  typedef struct packed {
    kw_str_t    text;
    logic [3:0] len;
    kind_t      kind;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{kw_str_t'("bind"),      4'd4, K_BIND},
    '{kw_str_t'("is"),        4'd2, K_IS},
    '{kw_str_t'("emit"),      4'd4, K_EMIT},
    '{kw_str_t'("check"),     4'd5, K_CHECK},
    '{kw_str_t'("otherwise"), 4'd9, K_OTHERW},
    '{kw_str_t'("cycle"),     4'd5, K_CYCLE},
    '{kw_str_t'("forge"),     4'd5, K_FORGE},
    '{kw_str_t'("yield"),     4'd5, K_YIELD},
    '{kw_str_t'("alive"),     4'd5, K_BOOL},
    '{kw_str_t'("dead"),      4'd4, K_BOOL},
    '{kw_str_t'("int"),       4'd3, K_INT_TY},
    '{kw_str_t'("bool"),      4'd4, K_BOOL_TY}
  };

  // Element j holds character j of the identifier
  typedef logic [KW_LEN_MAX-1:0][7:0] kw_text_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
    logic  bool_value;
  } kw_hit_t;

  function automatic kw_hit_t kw_match(input kw_text_t txt, input len_t len);
    kw_hit_t res;
    logic    ok;
    int      l;
    res = '{hit: 1'b0, kind: K_IDENT, bool_value: 1'b0};
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      l  = int'(KW_TABLE[i].len);
      ok = (len == len_t'(KW_TABLE[i].len));
      for (int j = 0; j < KW_LEN_MAX; j++) begin
        if (j < l) begin
          if (txt[j] != KW_TABLE[i].text[8*(l-1-j) +: 8]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        res.hit        = 1'b1;
        res.kind       = KW_TABLE[i].kind;
        res.bool_value = (KW_TABLE[i].kind == K_BOOL) && (l == 5);
      end
    end
    return res;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return c >= 8'd33 && c <= 8'd126;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/klx_src_if.sv =====
`default_nettype none

interface klx_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       is_end;

  modport source (output valid, output source_byte, output is_end, input ready);
  modport sink   (input valid, input source_byte, input is_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/klx_tok_if.sv =====
`default_nettype none

interface klx_tok_if #(
  parameter int LINE_BITS   = klx_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = klx_pkg::COLUMN_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [klx_pkg::KIND_BITS-1:0] token_kind;
  logic [LINE_BITS-1:0]          token_line;
  logic [COLUMN_BITS-1:0]        token_column;
  logic [klx_pkg::LEN_BITS-1:0]  token_length;
  logic                          bool_value;
  logic                          last;

  modport source (output valid, output token_kind, output token_line, output token_column,
                  output token_length, output bool_value, output last, input ready);
  modport sink   (input valid, input token_kind, input token_line, input token_column,
                  input token_length, input bool_value, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/klx_core.sv =====
`default_nettype none

module klx_core #(
  parameter int LINE_BITS   = klx_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = klx_pkg::COLUMN_BITS_DEF,
  parameter int KEYWORD_MAX = klx_pkg::KEYWORD_MAX_DEF,
  localparam int TOK_W = klx_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS + klx_pkg::LEN_BITS + 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       src_byte,
  input  wire logic             src_end,
  output logic      [TOK_W-1:0] tok_a,
  output logic      [TOK_W-1:0] tok_b,
  output logic      [1:0]       push_n
);

  localparam int IDX_W = (KEYWORD_MAX > 1) ? $clog2(KEYWORD_MAX) : 1;

  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] col_t;

  typedef struct packed {
    klx_pkg::kind_t kind;
    line_t          line;
    col_t           column;
    klx_pkg::len_t  length;
    logic           bool_value;
    logic           last;
  } tok_t;

  klx_pkg::lex_mode_t mode, mode_next;
  line_t              line, line_next;
  col_t               column, column_next;
  col_t               start_column, start_next;
  klx_pkg::len_t      lexeme_length, length_next;
  logic [7:0]         kbuf [KEYWORD_MAX];

  logic               buf_we;
  logic [IDX_W-1:0]   buf_idx;
  klx_pkg::kw_text_t  kw_text;
  klx_pkg::kw_hit_t   kw;

  // flushed token (ends before this byte) and started token (this byte)
  logic               fl_v, st_v, st_run, adv;
  klx_pkg::kind_t     fl_kind, st_kind;
  col_t               fl_col, st_col;
  klx_pkg::len_t      fl_len, st_len;
  logic               fl_bv;
  tok_t               ta, tb;
  logic               alnum;

  always_comb begin
    for (int j = 0; j < klx_pkg::KW_LEN_MAX; j++) begin
      kw_text[j] = kbuf[j];
    end
  end

  assign kw    = klx_pkg::kw_match(kw_text, lexeme_length);
  assign alnum = klx_pkg::is_alpha(src_byte) || klx_pkg::is_digit(src_byte);

  always_comb begin
    mode_next   = mode;
    line_next   = line;
    column_next = column;
    start_next  = start_column;
    length_next = lexeme_length;
    buf_we      = 1'b0;
    buf_idx     = '0;
    fl_v        = 1'b0;
    fl_kind     = klx_pkg::K_IDENT;
    fl_col      = start_column;
    fl_len      = lexeme_length;
    fl_bv       = 1'b0;
    st_run      = 1'b0;
    st_v        = 1'b0;
    st_kind     = klx_pkg::K_EOF;
    st_col      = column;
    st_len      = klx_pkg::len_t'(1);
    adv         = 1'b0;

    if (src_end) begin
      unique case (mode)
        klx_pkg::MODE_IDENT: begin
          fl_v    = 1'b1;
          fl_kind = kw.kind;
          fl_bv   = kw.bool_value;
        end
        klx_pkg::MODE_NUMBER: begin
          fl_v    = 1'b1;
          fl_kind = klx_pkg::K_INT;
        end
        klx_pkg::MODE_GT: begin
          fl_v    = 1'b1;
          fl_kind = klx_pkg::K_GT;
          fl_len  = klx_pkg::len_t'(1);
        end
        klx_pkg::MODE_LT: begin
          fl_v    = 1'b1;
          fl_kind = klx_pkg::K_LT;
          fl_len  = klx_pkg::len_t'(1);
        end
        klx_pkg::MODE_EQ, klx_pkg::MODE_BANG: begin
          fl_v    = 1'b1;
          fl_kind = klx_pkg::K_BADOP;
          fl_len  = klx_pkg::len_t'(1);
        end
        default: begin
        end
      endcase
      st_v        = 1'b1;
      st_kind     = klx_pkg::K_EOF;
      st_len      = '0;
      mode_next   = klx_pkg::MODE_IDLE;
      line_next   = line_t'(1);
      column_next = col_t'(1);
      start_next  = col_t'(1);
      length_next = '0;
    end else begin
      unique case (mode)
        klx_pkg::MODE_ERROR: begin
        end
        klx_pkg::MODE_IDENT: begin
          if (alnum) begin
            buf_we  = lexeme_length < klx_pkg::len_t'(KEYWORD_MAX);
            buf_idx = lexeme_length[IDX_W-1:0];
            if (lexeme_length != '1) length_next = lexeme_length + 1'b1;
            adv = 1'b1;
          end else begin
            fl_v    = 1'b1;
            fl_kind = kw.kind;
            fl_bv   = kw.bool_value;
            st_run  = 1'b1;
          end
        end
        klx_pkg::MODE_NUMBER: begin
          if (klx_pkg::is_digit(src_byte)) begin
            if (lexeme_length != '1) length_next = lexeme_length + 1'b1;
            adv = 1'b1;
          end else begin
            fl_v    = 1'b1;
            fl_kind = klx_pkg::K_INT;
            st_run  = 1'b1;
          end
        end
        klx_pkg::MODE_GT, klx_pkg::MODE_LT: begin
          fl_v = 1'b1;
          if (src_byte == "=") begin
            fl_kind   = (mode == klx_pkg::MODE_GT) ? klx_pkg::K_GE : klx_pkg::K_LE;
            fl_len    = klx_pkg::len_t'(2);
            adv       = 1'b1;
            mode_next = klx_pkg::MODE_IDLE;
          end else begin
            fl_kind = (mode == klx_pkg::MODE_GT) ? klx_pkg::K_GT : klx_pkg::K_LT;
            fl_len  = klx_pkg::len_t'(1);
            st_run  = 1'b1;
          end
        end
        klx_pkg::MODE_EQ, klx_pkg::MODE_BANG: begin
          fl_v = 1'b1;
          if (src_byte == "=") begin
            fl_kind   = (mode == klx_pkg::MODE_EQ) ? klx_pkg::K_EQEQ : klx_pkg::K_NE;
            fl_len    = klx_pkg::len_t'(2);
            adv       = 1'b1;
            mode_next = klx_pkg::MODE_IDLE;
          end else begin
            // lone = or !: byte is swallowed
            fl_kind   = klx_pkg::K_BADOP;
            fl_len    = klx_pkg::len_t'(1);
            mode_next = klx_pkg::MODE_ERROR;
          end
        end
        default: begin
          st_run = 1'b1;
        end
      endcase
    end

    if (st_run) begin
      mode_next = klx_pkg::MODE_IDLE;
      priority if (klx_pkg::is_space(src_byte)) begin
        adv = 1'b1;
      end else if (alnum) begin
        mode_next   = klx_pkg::is_alpha(src_byte) ? klx_pkg::MODE_IDENT : klx_pkg::MODE_NUMBER;
        start_next  = column;
        length_next = klx_pkg::len_t'(1);
        buf_we      = 1'b1;
        buf_idx     = '0;
        adv         = 1'b1;
      end else begin
        unique case (src_byte)
          "+": begin st_v = 1'b1; st_kind = klx_pkg::K_PLUS;   adv = 1'b1; end
          "-": begin st_v = 1'b1; st_kind = klx_pkg::K_MINUS;  adv = 1'b1; end
          "*": begin st_v = 1'b1; st_kind = klx_pkg::K_STAR;   adv = 1'b1; end
          "/": begin st_v = 1'b1; st_kind = klx_pkg::K_SLASH;  adv = 1'b1; end
          ":": begin st_v = 1'b1; st_kind = klx_pkg::K_COLON;  adv = 1'b1; end
          ";": begin st_v = 1'b1; st_kind = klx_pkg::K_SEMI;   adv = 1'b1; end
          ",": begin st_v = 1'b1; st_kind = klx_pkg::K_COMMA;  adv = 1'b1; end
          "(": begin st_v = 1'b1; st_kind = klx_pkg::K_LPAREN; adv = 1'b1; end
          ")": begin st_v = 1'b1; st_kind = klx_pkg::K_RPAREN; adv = 1'b1; end
          "{": begin st_v = 1'b1; st_kind = klx_pkg::K_LBRACE; adv = 1'b1; end
          "}": begin st_v = 1'b1; st_kind = klx_pkg::K_RBRACE; adv = 1'b1; end
          ">": begin mode_next = klx_pkg::MODE_GT;   start_next = column; adv = 1'b1; end
          "<": begin mode_next = klx_pkg::MODE_LT;   start_next = column; adv = 1'b1; end
          "=": begin mode_next = klx_pkg::MODE_EQ;   start_next = column; adv = 1'b1; end
          "!": begin mode_next = klx_pkg::MODE_BANG; start_next = column; adv = 1'b1; end
          default: begin
            // offending byte is not counted
            mode_next = klx_pkg::MODE_ERROR;
            st_v      = 1'b1;
            st_kind   = klx_pkg::is_print(src_byte) ? klx_pkg::K_BADSYM : klx_pkg::K_BADCHAR;
          end
        endcase
      end
    end

    if (adv) begin
      if (src_byte == 8'h0A) begin
        if (line != '1) line_next = line + 1'b1;
        column_next = col_t'(1);
      end else if (column != '1) begin
        column_next = column + 1'b1;
      end
    end
  end

  // Both tokens of one byte carry the line in force before the byte
  always_comb begin
    ta = '{kind: st_kind, line: line, column: st_col, length: st_len,
           bool_value: 1'b0, last: 1'b1};
    tb = ta;
    if (fl_v) begin
      ta = '{kind: fl_kind, line: line, column: fl_col, length: fl_len,
             bool_value: fl_bv, last: !st_v};
    end
    if (!fire) begin
      push_n = 2'd0;
    end else if (fl_v) begin
      push_n = st_v ? 2'd2 : 2'd1;
    end else begin
      push_n = st_v ? 2'd1 : 2'd0;
    end
  end

  assign tok_a = ta;
  assign tok_b = tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= klx_pkg::MODE_IDLE;
      line          <= line_t'(1);
      column        <= col_t'(1);
      start_column  <= col_t'(1);
      lexeme_length <= '0;
    end else if (fire) begin
      mode          <= mode_next;
      line          <= line_next;
      column        <= column_next;
      start_column  <= start_next;
      lexeme_length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && buf_we) begin
      kbuf[buf_idx] <= src_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/klx_out_fifo.sv =====
`default_nettype none

module klx_out_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [1:0]   push_n,
  input  wire logic [W-1:0] din_a,
  input  wire logic [W-1:0] din_b,
  output logic              room,
  input  wire logic         pop,
  output logic              valid,
  output logic      [W-1:0] dout
);

  localparam int DEPTH = klx_pkg::OUT_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count;
  logic          do_pop;

  assign valid  = count != '0;
  assign room   = count <= CW'(DEPTH - 2);
  assign dout   = mem[rp];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= din_a;
    if (push_n == 2'd2) mem[wp + PW'(1)] <= din_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push_n);
      rp    <= rp + PW'(do_pop);
      count <= count + CW'(push_n) - CW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/keyword_lexer_byte_stream.sv =====
// A byte accepted from src is held in the input register; when it fires, its tokens are pushed
// into the result queue, whose head drives tok. Throughput: one byte per cycle while the queue
// has room; a byte that yields two tokens needs two output transfers. The input stalls
// while more than two tokens wait in the 4-entry result queue.
// Reset (rst, synchronous): idle mode, line 1, column 1, queue empty. The keyword
// buffer holds no reset; only characters of the current identifier are compared.
`default_nettype none

module keyword_lexer_byte_stream #(
  parameter int LINE_BITS   = klx_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = klx_pkg::COLUMN_BITS_DEF,
  parameter int KEYWORD_MAX = klx_pkg::KEYWORD_MAX_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  klx_src_if.sink    src,
  klx_tok_if.source  tok
);

  localparam int TOK_W = klx_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS + klx_pkg::LEN_BITS + 2;

  typedef struct packed {
    klx_pkg::kind_t         kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    klx_pkg::len_t          length;
    logic                   bool_value;
    logic                   last;
  } tok_t;

  // Input register: holds one byte until the lexer has queue room for
  // the worst case of two tokens.
  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_end;
  logic       room;
  logic       fire;

  logic [TOK_W-1:0] tok_a, tok_b, head;
  logic [1:0]       push_n;
  tok_t             head_tok;

  assign fire      = item_valid && room;
  // take a new byte whenever the register is empty or the held one leaves in this cycle
  assign src.ready = !item_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (src.valid && src.ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      item_byte <= src.source_byte;
      item_end  <= src.is_end;
    end
  end

  // Lexer state and the per-byte decision: flush of a pending token,
  // then the token started by this byte (or end-of-file).
  klx_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .KEYWORD_MAX (KEYWORD_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .src_byte (item_byte),
    .src_end  (item_end),
    .tok_a    (tok_a),
    .tok_b    (tok_b),
    .push_n   (push_n)
  );

  // Result queue decouples the output transfer from the lexer.
  klx_out_fifo #(
    .W (TOK_W)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .din_a  (tok_a),
    .din_b  (tok_b),
    .room   (room),
    .pop    (tok.ready),
    .valid  (tok.valid),
    .dout   (head)
  );

  assign head_tok         = head;
  assign tok.token_kind   = head_tok.kind;
  assign tok.token_line   = head_tok.line;
  assign tok.token_column = head_tok.column;
  assign tok.token_length = head_tok.length;
  assign tok.bool_value   = head_tok.bool_value;
  assign tok.last         = head_tok.last;

endmodule

`default_nettype wire
